// File: design/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is low.
`define BCC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked implication, off while reset is low.
`define BCC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: design/bcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bcc_pkg;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_PRESS  = 3'd1,
    EV_SHORT  = 3'd2,
    EV_DOUBLE = 3'd3,
    EV_LONG   = 3'd4
  } event_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] REG_LONG_PRESS = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DCLICK_MIN = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DCLICK_MAX = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_IDLE_GAP   = 2'd3;

  localparam logic [7:0] LONG_PRESS_RST = 8'd100;
  localparam logic [5:0] DCLICK_MIN_RST = 6'd5;
  localparam logic [5:0] DCLICK_MAX_RST = 6'd32;
  localparam logic [5:0] IDLE_GAP_RST   = 6'd34;

  localparam logic [7:0] LONG_PRESS_CAP = 8'hFE;
  localparam logic [5:0] GAP_SAT        = 6'd63;

  typedef struct packed {
    logic [7:0] long_press_ticks;
    logic [5:0] dclick_min;
    logic [5:0] dclick_max;
    logic [5:0] idle_gap;
  } cfg_t;

  typedef struct packed {
    logic [7:0] history;
    logic [7:0] hold_count;
    logic [5:0] gap_count;
  } state_t;

endpackage

`default_nettype wire

// File: design/bcc_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// Key sample channel: one level per word.
interface bcc_key_if;
  logic valid;
  logic ready;
  logic key_level;

  modport source (output valid, output key_level, input ready);
  modport sink (input valid, input key_level, output ready);
endinterface

// Event channel: one classification code per word.
interface bcc_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;

  modport source (output valid, output event_res, input ready);
  modport sink (input valid, input event_res, output ready);
endinterface

`default_nettype wire

// File: design/bcc_step.sv
`timescale 1ns / 1ps
`default_nettype none

module bcc_step (
  input  wire logic            key_level_i,
  input  wire bcc_pkg::cfg_t   cfg_i,
  input  wire bcc_pkg::state_t state_i,
  output bcc_pkg::state_t      state_o,
  output bcc_pkg::event_e      event_o
);

  logic [7:0] lpt;
  logic [7:0] hist;
  logic [7:0] hold;
  logic [5:0] gap;
  logic       gap_idle;

  always_comb begin
    lpt  = (cfg_i.long_press_ticks == 8'hFF) ? bcc_pkg::LONG_PRESS_CAP
                                             : cfg_i.long_press_ticks;
    hist = {state_i.history[6:0], key_level_i};
    hold = state_i.hold_count;
    gap  = state_i.gap_count;
    event_o = bcc_pkg::EV_NONE;

    if (hist[2:0] == 3'b100) begin
      event_o = bcc_pkg::EV_PRESS;
      hold    = 8'd0;
    end

    gap_idle = (gap >= cfg_i.idle_gap);
    if (hist[3:0] == 4'b0011) begin
      if ((gap <= cfg_i.dclick_max) && (gap > cfg_i.dclick_min)) begin
        event_o = bcc_pkg::EV_DOUBLE;
      end else if ((hold != (lpt + 8'd1)) && gap_idle) begin
        event_o = bcc_pkg::EV_SHORT;
      end
      if (gap_idle) begin
        gap = 6'd0;
      end
    end

    // saturate at idle_gap + 1, never past the counter's top
    if ((gap != bcc_pkg::GAP_SAT) && (gap <= cfg_i.idle_gap)) begin
      gap = gap + 6'd1;
    end

    if (hist[3:0] == 4'b0000) begin
      if (hold < lpt) begin
        hold = hold + 8'd1;
      end else if (hold == lpt) begin
        hold    = hold + 8'd1;
        event_o = bcc_pkg::EV_LONG;
      end
    end

    state_o.history    = hist;
    state_o.hold_count = hold;
    state_o.gap_count  = gap;
  end

endmodule

`default_nettype wire

// File: design/button_click_classifier.sv
// Channel  Dir  Payload         Word
// key_i    in   key_level [0]   one sampled pin level
// evt_o    out  event_res [2:0] one event code per sample
// cfg_*    in   8-bit data      register write, index 0..3
//
// One sample per cycle while the output is not stalled; an accepted sample
// passes the input register, then the result register, before it can leave.
// The classify step is one pass of compare/count logic on the history,
// hold and gap registers, updated as a word moves into the result register.
// A stalled output holds its word; the input register still takes one more.
// Reset restores register defaults, history all ones, counters zero.
`timescale 1ns / 1ps
`default_nettype none

module button_click_classifier (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  bcc_key_if.sink                             key_i,
  bcc_evt_if.source                           evt_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [bcc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [bcc_pkg::CfgDataW-1:0]   cfg_data_i
);

  bcc_pkg::cfg_t   cfg_q;
  bcc_pkg::state_t state_q;
  bcc_pkg::state_t state_d;
  bcc_pkg::event_e event_d;
  bcc_pkg::event_e evt_q;

  logic key_q;
  logic in_valid_q;
  logic out_valid_q;
  logic advance;

  assign advance     = in_valid_q && (!out_valid_q || evt_o.ready);
  assign key_i.ready = !in_valid_q || advance;

  assign evt_o.valid     = out_valid_q;
  assign evt_o.event_res = evt_q;

  bcc_step u_step (
    .key_level_i (key_q),
    .cfg_i       (cfg_q),
    .state_i     (state_q),
    .state_o     (state_d),
    .event_o     (event_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks <= bcc_pkg::LONG_PRESS_RST;
      cfg_q.dclick_min       <= bcc_pkg::DCLICK_MIN_RST;
      cfg_q.dclick_max       <= bcc_pkg::DCLICK_MAX_RST;
      cfg_q.idle_gap         <= bcc_pkg::IDLE_GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bcc_pkg::REG_LONG_PRESS: cfg_q.long_press_ticks <= cfg_data_i;
        bcc_pkg::REG_DCLICK_MIN: cfg_q.dclick_min       <= cfg_data_i[5:0];
        bcc_pkg::REG_DCLICK_MAX: cfg_q.dclick_max       <= cfg_data_i[5:0];
        bcc_pkg::REG_IDLE_GAP:   cfg_q.idle_gap         <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{history: 8'hFF, hold_count: 8'd0, gap_count: 6'd0};
    end else begin
      if (key_i.valid && key_i.ready) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end

      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (evt_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_i.valid && key_i.ready) begin
      key_q <= key_i.key_level;
    end
    if (advance) begin
      evt_q <= event_d;
    end
  end

endmodule

`default_nettype wire

// File: design/bcc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bcc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       key_valid_i,
  input wire logic       key_ready_i,
  input wire logic       evt_valid_i,
  input wire logic       evt_ready_i,
  input wire logic [2:0] evt_res_i
);

  // stalled result word keeps its code
  `BCC_ASSERT_IMP(a_evt_hold, clk_i, rst_ni, evt_valid_i && !evt_ready_i, ##1 (evt_valid_i && $stable(evt_res_i)), "event word changed under stall")

  // only defined event codes leave the block
  `BCC_ASSERT_IMP(a_evt_code, clk_i, rst_ni, evt_valid_i, evt_res_i <= bcc_pkg::EV_LONG, "undefined event code")

  // input side only backs up when both stages are full and output is stalled
  `BCC_ASSERT_IMP(a_in_stall, clk_i, rst_ni, !key_ready_i, evt_valid_i && !evt_ready_i, "input stalled without output backpressure")

  // a word taken into a free pipe reaches the output through the input and result registers
  `BCC_ASSERT_IMP(a_latency, clk_i, rst_ni, key_valid_i && key_ready_i && !evt_valid_i, ##2 evt_valid_i, "accepted word did not reach the output")

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .key_valid_i (key_i.valid),
  .key_ready_i (key_i.ready),
  .evt_valid_i (evt_o.valid),
  .evt_ready_i (evt_o.ready),
  .evt_res_i   (evt_o.event_res)
);

`default_nettype wire
